// ===== hw/rtl/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, constants and helpers for the button sequence challenge.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int MAX_LENGTH = 8;
  localparam int LEN_W      = $clog2(MAX_LENGTH + 1);
  localparam int SEQ_W      = 2 * MAX_LENGTH;
  localparam int CFG_AW     = 5;

  localparam logic [7:0] MAX_LEN8     = 8'(MAX_LENGTH);
  localparam logic [7:0] CMD_FIXED_LO = 8'h30;
  localparam logic [7:0] CMD_FIXED_HI = 8'h33;
  localparam logic [7:0] BTN_MAX      = 8'h03;

  // reset values of the configuration registers
  localparam logic [31:0] TIMEOUT_RST  = 32'd60000;
  localparam logic [15:0] FLASH_ON_RST = 16'd420;
  localparam logic [15:0] FLASH_OFF_RST = 16'd180;
  localparam logic [15:0] GAP_RST      = 16'd700;
  localparam logic [3:0]  ATTEMPT_RST  = 4'd3;
  localparam logic [3:0]  DEFLEN_RST   = 4'd4;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_BUTTON = 2'd1,
    OP_START  = 2'd2,
    OP_CANCEL = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    REG_TIMEOUT   = 3'd0,
    REG_FLASH_ON  = 3'd1,
    REG_FLASH_OFF = 3'd2,
    REG_GAP       = 3'd3,
    REG_ATTEMPT   = 3'd4,
    REG_DEFLEN    = 3'd5
  } reg_idx_t;

  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_SHOW     = 6'b000010,
    PH_WAIT     = 6'b000100,
    PH_APPROVED = 6'b001000,
    PH_REJECTED = 6'b010000,
    PH_TIMEOUT  = 6'b100000
  } phase_t;

  localparam logic [2:0] PHC_IDLE     = 3'd0;
  localparam logic [2:0] PHC_SHOW     = 3'd1;
  localparam logic [2:0] PHC_WAIT     = 3'd2;
  localparam logic [2:0] PHC_APPROVED = 3'd3;
  localparam logic [2:0] PHC_REJECTED = 3'd4;
  localparam logic [2:0] PHC_TIMEOUT  = 3'd5;

  typedef struct packed {
    logic [31:0] timeout_limit_ms;
    logic [15:0] flash_on_ms;
    logic [15:0] flash_off_ms;
    logic [15:0] round_gap_ms;
    logic [3:0]  attempt_limit;
    logic [3:0]  default_length;
  } cfg_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [31:0] time_ms;
    logic [7:0]  button_number;
    logic [7:0]  command_code;
    logic [7:0]  requested_length;
    logic [15:0] random_pairs;
  } item_t;

  typedef struct packed {
    logic [3:0] led_lights;
    logic       event_flag;
    logic [2:0] phase;
  } result_t;

  function automatic logic [2:0] phase_code(phase_t p);
    logic [2:0] c;
    unique case (p)
      PH_IDLE:     c = PHC_IDLE;
      PH_SHOW:     c = PHC_SHOW;
      PH_WAIT:     c = PHC_WAIT;
      PH_APPROVED: c = PHC_APPROVED;
      PH_REJECTED: c = PHC_REJECTED;
      PH_TIMEOUT:  c = PHC_TIMEOUT;
      default:     c = PHC_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/bsc_cfg.sv =====
// ----------------------------------------------------------------------------
// bsc_cfg
// APB register file holding the challenge timing and limit settings.
// ----------------------------------------------------------------------------
module bsc_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bsc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output bsc_pkg::cfg_t              cfg
);
  import bsc_pkg::*;

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_limit_ms <= TIMEOUT_RST;
      cfg_r.flash_on_ms      <= FLASH_ON_RST;
      cfg_r.flash_off_ms     <= FLASH_OFF_RST;
      cfg_r.round_gap_ms     <= GAP_RST;
      cfg_r.attempt_limit    <= ATTEMPT_RST;
      cfg_r.default_length   <= DEFLEN_RST;
    end else if (wr_en) begin
      case (idx)
        REG_TIMEOUT:   cfg_r.timeout_limit_ms <= pwdata;
        REG_FLASH_ON:  cfg_r.flash_on_ms      <= pwdata[15:0];
        REG_FLASH_OFF: cfg_r.flash_off_ms     <= pwdata[15:0];
        REG_GAP:       cfg_r.round_gap_ms     <= pwdata[15:0];
        REG_ATTEMPT:   cfg_r.attempt_limit    <= pwdata[3:0];
        REG_DEFLEN:    cfg_r.default_length   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TIMEOUT:   prdata = cfg_r.timeout_limit_ms;
      REG_FLASH_ON:  prdata = {16'd0, cfg_r.flash_on_ms};
      REG_FLASH_OFF: prdata = {16'd0, cfg_r.flash_off_ms};
      REG_GAP:       prdata = {16'd0, cfg_r.round_gap_ms};
      REG_ATTEMPT:   prdata = {28'd0, cfg_r.attempt_limit};
      REG_DEFLEN:    prdata = {28'd0, cfg_r.default_length};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/bsc_engine.sv =====
// ----------------------------------------------------------------------------
// bsc_engine
// Challenge state and the single-pass step logic for one transaction.
// ----------------------------------------------------------------------------
module bsc_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  bsc_pkg::item_t   item,
  input  bsc_pkg::cfg_t    cfg,
  output bsc_pkg::result_t res
);
  import bsc_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [SEQ_W-1:0]   seq_r, seq_nxt;
  logic [SEQ_W-1:0]   show_seq_r, show_seq_nxt;
  logic [SEQ_W-1:0]   match_seq_r, match_seq_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [LEN_W-1:0]   match_r, match_nxt;
  logic [LEN_W-1:0]   idx_r, idx_nxt;
  logic [3:0]         att_r, att_nxt;
  logic               dark_r, dark_nxt;
  logic [31:0]        show_mark_r, show_mark_nxt;
  logic [31:0]        start_mark_r, start_mark_nxt;

  logic [7:0]         def8;
  logic [7:0]         len8;
  logic               fixed_pat;
  logic [SEQ_W+15:0]  rnd_wide;
  logic [SEQ_W-1:0]   start_seq;
  logic [31:0]        sm;
  logic [31:0]        shm;
  logic [31:0]        elapsed;
  logic [31:0]        dt;
  logic               show_done;
  logic               btn_hit;
  logic [LEN_W-1:0]   match_inc;
  logic [3:0]         att_dec;
  logic               active;

  always_comb begin
    // step count for a start transaction
    def8 = {4'd0, cfg.default_length};
    if (def8 == 8'd0) begin
      def8 = 8'd1;
    end else if (def8 > MAX_LEN8) begin
      def8 = MAX_LEN8;
    end
    if (item.requested_length == 8'd0 || item.requested_length > MAX_LEN8) begin
      len8 = def8;
    end else begin
      len8 = item.requested_length;
    end

    fixed_pat = (item.command_code >= CMD_FIXED_LO) && (item.command_code <= CMD_FIXED_HI);
    // steps past the random field read as zero
    rnd_wide  = {{SEQ_W{1'b0}}, item.random_pairs};
    for (int i = 0; i < MAX_LENGTH; i++) begin
      start_seq[2*i +: 2] = fixed_pat ? 2'(i) : rnd_wide[2*i +: 2];
    end

    // zero marks mean unset and are taken from this tick
    sm        = (start_mark_r == 32'd0) ? item.time_ms : start_mark_r;
    shm       = (show_mark_r == 32'd0) ? item.time_ms : show_mark_r;
    elapsed   = item.time_ms - sm;
    dt        = item.time_ms - shm;
    show_done = idx_r >= len_r;
    btn_hit   = (match_r < LEN_W'(MAX_LENGTH)) &&
                (item.button_number == {6'd0, match_seq_r[1:0]});
    match_inc = match_r + LEN_W'(1);
    att_dec   = (att_r != 4'd0) ? att_r - 4'd1 : 4'd0;
    active    = (phase_r == PH_SHOW) || (phase_r == PH_WAIT);

    phase_nxt      = phase_r;
    seq_nxt        = seq_r;
    show_seq_nxt   = show_seq_r;
    match_seq_nxt  = match_seq_r;
    len_nxt        = len_r;
    match_nxt      = match_r;
    idx_nxt        = idx_r;
    att_nxt        = att_r;
    dark_nxt       = dark_r;
    show_mark_nxt  = show_mark_r;
    start_mark_nxt = start_mark_r;
    res.led_lights = 4'd0;
    res.event_flag = 1'b0;

    if (fire) begin
      unique case (item.opcode)
        OP_TICK: begin
          if (active) begin
            start_mark_nxt = sm;
            if (elapsed > cfg.timeout_limit_ms) begin
              phase_nxt      = PH_TIMEOUT;
              res.event_flag = 1'b1;
            end else if (phase_r == PH_SHOW) begin
              show_mark_nxt = shm;
              if (show_done) begin
                if (dt >= {16'd0, cfg.round_gap_ms}) begin
                  phase_nxt      = PH_WAIT;
                  res.event_flag = 1'b1;
                end
              end else if (!dark_r) begin
                if (dt < {16'd0, cfg.flash_on_ms}) begin
                  res.led_lights = 4'b0001 << show_seq_r[1:0];
                end else begin
                  dark_nxt      = 1'b1;
                  show_mark_nxt = item.time_ms;
                end
              end else if (dt >= {16'd0, cfg.flash_off_ms}) begin
                dark_nxt      = 1'b0;
                idx_nxt       = idx_r + LEN_W'(1);
                show_mark_nxt = item.time_ms;
                show_seq_nxt  = show_seq_r >> 2;
              end
            end else begin
              // one led per correct press, at most four
              for (int i = 0; i < 4; i++) begin
                res.led_lights[i] = 8'(match_r) > 8'(i);
              end
            end
          end
        end
        OP_BUTTON: begin
          if (active && item.button_number <= BTN_MAX) begin
            res.event_flag = 1'b1;
            phase_nxt      = PH_WAIT;
            if (btn_hit) begin
              match_nxt     = match_inc;
              match_seq_nxt = match_seq_r >> 2;
              if (match_inc >= len_r) begin
                phase_nxt = PH_APPROVED;
              end
            end else begin
              match_nxt     = '0;
              match_seq_nxt = seq_r;
              att_nxt       = att_dec;
              if (att_dec == 4'd0) begin
                phase_nxt = PH_REJECTED;
              end else begin
                phase_nxt     = PH_SHOW;
                idx_nxt       = '0;
                dark_nxt      = 1'b0;
                show_mark_nxt = 32'd0;
                show_seq_nxt  = seq_r;
              end
            end
          end
        end
        OP_START: begin
          phase_nxt      = PH_SHOW;
          seq_nxt        = start_seq;
          show_seq_nxt   = start_seq;
          match_seq_nxt  = start_seq;
          len_nxt        = LEN_W'(len8);
          match_nxt      = '0;
          idx_nxt        = '0;
          att_nxt        = cfg.attempt_limit;
          dark_nxt       = 1'b0;
          show_mark_nxt  = 32'd0;
          start_mark_nxt = 32'd0;
        end
        OP_CANCEL: begin
          phase_nxt      = PH_IDLE;
          seq_nxt        = '0;
          show_seq_nxt   = '0;
          match_seq_nxt  = '0;
          len_nxt        = '0;
          match_nxt      = '0;
          idx_nxt        = '0;
          att_nxt        = 4'd0;
          dark_nxt       = 1'b0;
          show_mark_nxt  = 32'd0;
          start_mark_nxt = 32'd0;
        end
      endcase
    end

    res.phase = phase_code(phase_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      seq_r        <= '0;
      show_seq_r   <= '0;
      match_seq_r  <= '0;
      len_r        <= '0;
      match_r      <= '0;
      idx_r        <= '0;
      att_r        <= 4'd0;
      dark_r       <= 1'b0;
      show_mark_r  <= 32'd0;
      start_mark_r <= 32'd0;
    end else begin
      phase_r      <= phase_nxt;
      seq_r        <= seq_nxt;
      show_seq_r   <= show_seq_nxt;
      match_seq_r  <= match_seq_nxt;
      len_r        <= len_nxt;
      match_r      <= match_nxt;
      idx_r        <= idx_nxt;
      att_r        <= att_nxt;
      dark_r       <= dark_nxt;
      show_mark_r  <= show_mark_nxt;
      start_mark_r <= start_mark_nxt;
    end
  end

`ifndef SYNTH
  a_match_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SHOW || phase_r == PH_WAIT) |-> match_r < len_r)
    else $error("match position reached length while challenge active");

  a_idx_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= len_r)
    else $error("show index ran past sequence length");

  a_start_shows: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.opcode == OP_START |=> phase_r == PH_SHOW && len_r != '0)
    else $error("start did not enter showing with a nonzero length");

  a_show_one_led: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.opcode == OP_TICK && phase_r == PH_SHOW |-> $onehot0(res.led_lights))
    else $error("more than one led lit while showing");
`endif

endmodule

// ===== hw/rtl/button_sequence_challenge.sv =====
// path: a transaction goes from the input register through the engine into the result register
// throughput: one transaction per cycle when the output is not stalled; every opcode takes a single pass
// the input register frees whenever the result register is empty or being taken
// reset: synchronous active-low rst_n clears the challenge to idle and loads
// the register defaults; no clearing pass is needed
// ----------------------------------------------------------------------------
// button_sequence_challenge
// Four-button confirmation challenge with led display and timeout checking.
// ----------------------------------------------------------------------------
module button_sequence_challenge (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_opcode,
  input  logic [31:0]                in_time_ms,
  input  logic [7:0]                 in_button_number,
  input  logic [7:0]                 in_command_code,
  input  logic [7:0]                 in_requested_length,
  input  logic [15:0]                in_random_pairs,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [3:0]                 out_led_lights,
  output logic                       out_event_flag,
  output logic [2:0]                 out_phase,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bsc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import bsc_pkg::*;

  logic    in_valid_r;
  item_t   item_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t res;
  cfg_t    cfg;
  logic    advance;
  logic    fire;
  logic    in_take;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  bsc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bsc_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.opcode           <= opcode_t'(in_opcode);
      item_r.time_ms          <= in_time_ms;
      item_r.button_number    <= in_button_number;
      item_r.command_code     <= in_command_code;
      item_r.requested_length <= in_requested_length;
      item_r.random_pairs     <= in_random_pairs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_led_lights = out_res_r.led_lights;
  assign out_event_flag = out_res_r.event_flag;
  assign out_phase      = out_res_r.phase;

endmodule
